FILE: rtl/core/soh_dle_deframer_crc16_core_macros.svh
// Assertion macros shared by the deframer checker.
// No dependencies; every macro samples on i_clk and is disabled while i_rst_n is low.
`ifndef SOH_DLE_DEFRAMER_CRC16_CORE_MACROS_SVH
`define SOH_DLE_DEFRAMER_CRC16_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SDC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("deframer check failed");

// The consequent must hold in the cycle after the antecedent.
`define SDC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("deframer check failed");

`endif

FILE: rtl/core/sdc_pkg.sv
// Package for the SOH/DLE/EOT deframer: item types, framing codes and the CRC step.
// No dependencies.
package sdc_pkg;

    localparam logic [7:0] SOH_CODE = 8'h01;
    localparam logic [7:0] DLE_CODE = 8'h10;
    localparam logic [7:0] EOT_CODE = 8'h04;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    localparam logic REQ_BYTE  = 1'b0;
    localparam logic REQ_CLEAR = 1'b1;

    localparam logic [1:0] FS_NONE = 2'd0;
    localparam logic [1:0] FS_GOOD = 2'd1;
    localparam logic [1:0] FS_BAD  = 2'd2;

    localparam int LEN_W = 10;

    typedef struct packed {
        logic       req_type;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        logic             payload_valid;
        logic [7:0]       payload_byte;
        logic [1:0]       frame_status;
        logic             frame_ready;
        logic [LEN_W-1:0] frame_length;
    } t_out_item;

    // One byte of CRC-16/XMODEM, MSB first, no reflection.
    function automatic logic [15:0] crc16_feed(logic [15:0] crc, logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

FILE: rtl/core/soh_dle_deframer_crc16_core.sv
// Top level of the SOH/DLE/EOT deframer with a CRC-16/XMODEM trailer check.
// Depends on sdc_pkg.
//
// Channel | Handshake                  | Payload
// --------+----------------------------+-------------------------------
// input   | i_in_valid / o_in_ready    | i_in_data  (sdc_pkg::t_in_item)
// output  | o_out_valid / i_out_ready  | o_out_data (sdc_pkg::t_out_item)
//
// One item is accepted per cycle while the output is not stalled, and every item
// yields exactly one result. A result passes through the input register and then
// the result register. The rate is set by the single byte-wide CRC step and
// compare between those two registers.
// Reset (synchronous, active low) clears both valid flags and all frame state.
// A stalled output holds the result register; the input register still takes
// one more transfer, after which o_in_ready drops until the output moves.
module soh_dle_deframer_crc16_core #(
    parameter int BUFFER_BYTES = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  sdc_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output sdc_pkg::t_out_item o_out_data
);
    import sdc_pkg::*;

    // The count must be able to hold the buffer size itself, since the wrap
    // back to zero happens only when the next byte is processed.
    localparam int CNT_W = $clog2(BUFFER_BYTES + 1);
    localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(BUFFER_BYTES);
    localparam logic [CNT_W-1:0] CNT_TWO   = CNT_W'(2);

    // Input register.
    logic      r_in_valid;
    t_in_item  r_in_data;

    // Result register.
    logic      r_out_valid;
    t_out_item r_out_data;
    t_out_item n_out_data;

    // Frame state.
    logic             r_escape;
    logic             n_escape;
    logic             r_ready_flag;
    logic             n_ready_flag;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [15:0]      r_crc;
    logic [15:0]      n_crc;
    logic [7:0]       r_held0;
    logic [7:0]       n_held0;
    logic [7:0]       r_held1;
    logic [7:0]       n_held1;

    // The item in the input register moves on when the result register is
    // empty or its result is being taken this cycle.
    logic adv;
    logic in_fire;

    assign adv        = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || adv;
    assign in_fire    = i_in_valid && o_in_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_fire) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_data <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_data <= n_out_data;
        end
    end

    // Frame state advances exactly once per item, when that item's result
    // is written into the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_escape     <= 1'b0;
            r_ready_flag <= 1'b0;
            r_count      <= '0;
            r_crc        <= '0;
            r_held0      <= '0;
            r_held1      <= '0;
        end else if (adv) begin
            r_escape     <= n_escape;
            r_ready_flag <= n_ready_flag;
            r_count      <= n_count;
            r_crc        <= n_crc;
            r_held0      <= n_held0;
            r_held1      <= n_held1;
        end
    end

    // Per-item logic. Stored bytes are delayed by two so that the CRC trailer
    // never enters the running CRC; each byte leaving the delay is payload.
    logic [CNT_W-1:0] cnt0;
    logic [15:0]      crc0;
    logic [CNT_W-1:0] len_full;
    logic             do_store;
    logic             crc_match;
    logic [7:0]       b;

    always_comb begin
        b          = r_in_data.rx_byte;
        n_escape     = r_escape;
        n_ready_flag = r_ready_flag;
        n_count      = r_count;
        n_crc        = r_crc;
        n_held0      = r_held0;
        n_held1      = r_held1;
        n_out_data   = '0;
        do_store     = 1'b0;

        // Wrap of the byte count at the buffer size, applied to every byte
        // that is actually processed.
        if (r_count == CNT_LIMIT) begin
            cnt0 = '0;
            crc0 = '0;
        end else begin
            cnt0 = r_count;
            crc0 = r_crc;
        end
        len_full  = cnt0 - CNT_TWO;
        crc_match = ({r_held1, r_held0} == crc0);

        if (r_in_data.req_type == REQ_CLEAR) begin
            // Clear request only drops the ready flag; the result is all zero.
            n_ready_flag = 1'b0;
        end else if (r_ready_flag) begin
            // A good frame is held: link bytes are ignored.
            n_out_data.frame_ready = 1'b1;
        end else begin
            n_count = cnt0;
            n_crc   = crc0;
            if (r_escape) begin
                n_escape = 1'b0;
                do_store = 1'b1;
            end else if (b == SOH_CODE) begin
                n_count = '0;
                n_crc   = '0;
            end else if (b == DLE_CODE) begin
                n_escape = 1'b1;
            end else if (b == EOT_CODE) begin
                // The count is left as is; later bytes extend it.
                if (cnt0 > CNT_TWO && crc_match) begin
                    n_ready_flag            = 1'b1;
                    n_out_data.frame_status = FS_GOOD;
                end else begin
                    n_out_data.frame_status = FS_BAD;
                end
                if (cnt0 >= CNT_TWO) begin
                    n_out_data.frame_length = LEN_W'(len_full);
                end
            end else begin
                do_store = 1'b1;
            end

            if (do_store) begin
                if (cnt0 >= CNT_TWO) begin
                    n_crc                    = crc16_feed(crc0, r_held0);
                    n_out_data.payload_valid = 1'b1;
                    n_out_data.payload_byte  = r_held0;
                    n_held0                  = r_held1;
                    n_held1                  = b;
                end else if (cnt0[0]) begin
                    n_held1 = b;
                end else begin
                    n_held0 = b;
                end
                n_count = cnt0 + CNT_W'(1);
            end
            n_out_data.frame_ready = n_ready_flag;
        end
    end

endmodule

FILE: rtl/core/sdc_core_checker.sv
// Port-level checker for the deframer, bound to soh_dle_deframer_crc16_core.
// Depends on sdc_pkg and soh_dle_deframer_crc16_core_macros.svh.
`include "soh_dle_deframer_crc16_core_macros.svh"

module sdc_core_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input sdc_pkg::t_in_item  i_in_data,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input sdc_pkg::t_out_item o_out_data
);
    import sdc_pkg::*;

    // A result that ends a frame, and the field relations it must show.
    logic end_seen;
    logic end_fields_ok;

    assign end_seen      = o_out_valid && (o_out_data.frame_status != FS_NONE);
    assign end_fields_ok = !o_out_data.payload_valid &&
        (o_out_data.frame_ready == (o_out_data.frame_status == FS_GOOD));

    // A pending result is held until it is taken.
    `SDC_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid)
    `SDC_ASSERT_NEXT(a_out_stable, o_out_valid && !i_out_ready, $stable(o_out_data))

    // Input back-pressure only ever comes from a stalled output.
    `SDC_ASSERT_SAME(a_ready_only_on_stall, !o_in_ready, o_out_valid && !i_out_ready)

    // A frame end never carries a payload byte, and its ready flag follows its status.
    `SDC_ASSERT_SAME(a_end_fields, end_seen, end_fields_ok)

endmodule

bind soh_dle_deframer_crc16_core sdc_core_checker u_sdc_core_checker (.*);

FILE: tb/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for soh_dle_deframer_crc16_core: framed and noisy byte traffic under
// random handshake pressure, every result checked field by field against a behavioral model.
// Depends on sdc_pkg and the deframer core; needs nothing else.
module tb;
    import sdc_pkg::*;

    localparam int BUF_BYTES   = 1024;
    localparam int ITEM_TARGET = 1450;
    localparam int LONG_HOLD   = 200;
    localparam int SETTLE      = 6;

    typedef logic [7:0] byte_q_t[$];

    // Tracks the deframer's state from accepted input transfers and keeps a queue of the
    // results that are still owed on the output. The block yields exactly one result per
    // accepted item, so the queue stays in input order.
    class deframe_scoreboard;
        t_out_item   owed_outputs[$];
        int          fail_count;
        bit          after_dle;
        bit          frame_held;
        int unsigned stored_count;
        logic [15:0] crc_acc;
        logic [7:0]  tail[2];

        function new();
            fail_count   = 0;
            after_dle    = 1'b0;
            frame_held   = 1'b0;
            stored_count = 0;
            crc_acc      = '0;
            tail[0]      = '0;
            tail[1]      = '0;
        endfunction

        // CRC-16/XMODEM, one message bit at a time.
        static function logic [15:0] crc_step(logic [15:0] crc, logic [7:0] b);
            logic [15:0] c;
            logic        fb;
            c = crc;
            for (int i = 7; i >= 0; i--) begin
                fb = c[15] ^ b[i];
                c  = {c[14:0], 1'b0};
                if (fb) begin
                    c = c ^ CRC_POLY;
                end
            end
            return c;
        endfunction

        // The newest two stored bytes may be the trailer, so a byte only counts as payload
        // once two more have arrived behind it.
        function void shift_in(logic [7:0] b, inout t_out_item r);
            if (stored_count >= 2) begin
                crc_acc         = crc_step(crc_acc, tail[0]);
                r.payload_valid = 1'b1;
                r.payload_byte  = tail[0];
                tail[0]         = tail[1];
                tail[1]         = b;
            end else begin
                tail[stored_count[0]] = b;
            end
            stored_count++;
        endfunction

        // Notes one accepted input transfer and queues the result it owes.
        function void absorb_item(t_in_item it);
            t_out_item r;
            r = '0;
            if (it.req_type == REQ_CLEAR) begin
                frame_held = 1'b0;
            end else if (frame_held) begin
                r.frame_ready = 1'b1;
            end else begin
                if (stored_count >= BUF_BYTES) begin
                    stored_count = 0;
                    crc_acc      = '0;
                end
                if (after_dle) begin
                    after_dle = 1'b0;
                    shift_in(it.rx_byte, r);
                end else if (it.rx_byte == SOH_CODE) begin
                    stored_count = 0;
                    crc_acc      = '0;
                end else if (it.rx_byte == DLE_CODE) begin
                    after_dle = 1'b1;
                end else if (it.rx_byte == EOT_CODE) begin
                    if (stored_count > 2 && {tail[1], tail[0]} == crc_acc) begin
                        frame_held     = 1'b1;
                        r.frame_status = FS_GOOD;
                    end else begin
                        r.frame_status = FS_BAD;
                    end
                    if (stored_count >= 2) begin
                        r.frame_length = LEN_W'(stored_count - 2);
                    end
                end else begin
                    shift_in(it.rx_byte, r);
                end
                r.frame_ready = frame_held;
            end
            owed_outputs.push_back(r);
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                $error("%s: expected %0h, actual %0h", name, want, got);
                fail_count++;
            end
        endfunction

        function void check_output(t_out_item got);
            t_out_item want;
            if (owed_outputs.size() == 0) begin
                $error("output transfer with nothing expected: %h", got);
                fail_count++;
            end else begin
                want = owed_outputs.pop_front();
                compare_field("payload_valid", want.payload_valid, got.payload_valid);
                compare_field("payload_byte", want.payload_byte, got.payload_byte);
                compare_field("frame_status", want.frame_status, got.frame_status);
                compare_field("frame_ready", want.frame_ready, got.frame_ready);
                compare_field("frame_length", want.frame_length, got.frame_length);
            end
        endfunction
    endclass

    typedef enum int {RX_OPEN, RX_COIN, RX_PERIODIC, RX_STARVED} rx_mode_t;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    t_in_item  in_data   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_data;

    deframe_scoreboard sb;
    t_in_item          frame_q[$];
    int                burst_left    = 0;
    int                counted_items = 0;
    int                hold_left     = 0;
    rx_mode_t          rx_mode       = RX_OPEN;
    int                rx_mode_left  = 0;
    int                rx_cycle      = 0;

    soh_dle_deframer_crc16_core #(
        .BUFFER_BYTES(BUF_BYTES)
    ) uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_data)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Hard stop in case the block hangs or loses a result.
    initial begin
        #5000000;
        $display("Regression FAIL");
        $finish;
    end

    // Output side. A transfer happens at the edge where valid and ready were both high
    // just before it; both are read here before any update of that edge lands. The ready
    // pattern switches between randomly chosen modes, and a long hold-off requested
    // by the stimulus freezes it completely so the core backs up into its input.
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            sb.check_output(out_data);
        end
        rx_cycle++;
        if (hold_left > 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode      = rx_mode_t'($urandom_range(0, 3));
                rx_mode_left = $urandom_range(20, 120);
            end
            rx_mode_left--;
            case (rx_mode)
                RX_OPEN: begin
                    out_ready <= 1'b1;
                end
                RX_COIN: begin
                    out_ready <= ($urandom_range(0, 99) < 60);
                end
                RX_PERIODIC: begin
                    out_ready <= (rx_cycle % 4 != 3);
                end
                default: begin
                    out_ready <= ($urandom_range(0, 99) < 15);
                end
            endcase
        end
    end

    // Random byte, biased toward the framing codes and the all-zero and all-one values.
    function automatic logic [7:0] pick_byte(int special_pct);
        logic [7:0] marks[5];
        marks = '{SOH_CODE, DLE_CODE, EOT_CODE, 8'h00, 8'hFF};
        if ($urandom_range(0, 99) < special_pct) begin
            return marks[$urandom_range(0, 4)];
        end
        return 8'($urandom);
    endfunction

    function automatic byte_q_t rand_payload(int len);
        byte_q_t q;
        for (int i = 0; i < len; i++) begin
            q.push_back(pick_byte(25));
        end
        return q;
    endfunction

    function automatic void put_raw(logic req, logic [7:0] b);
        t_in_item it;
        it.req_type = req;
        it.rx_byte  = b;
        frame_q.push_back(it);
    endfunction

    // Framing codes must be escaped to count as data; plain bytes are escaped now and then
    // as well, since the deframer takes any byte after DLE literally.
    function automatic void put_data(logic [7:0] b);
        if (b == SOH_CODE || b == DLE_CODE || b == EOT_CODE || $urandom_range(0, 19) == 0) begin
            put_raw(REQ_BYTE, DLE_CODE);
        end
        put_raw(REQ_BYTE, b);
    endfunction

    // Queues one frame: optional SOH, escaped payload, CRC trailer low byte first, EOT.
    // With corrupt set, one bit of the payload or trailer is flipped before escaping.
    function automatic void put_frame(byte_q_t payload, bit lead_soh, bit corrupt);
        byte_q_t     body;
        logic [15:0] crc;
        int          pos;
        body = payload;
        crc  = '0;
        foreach (payload[i]) begin
            crc = deframe_scoreboard::crc_step(crc, payload[i]);
        end
        body.push_back(crc[7:0]);
        body.push_back(crc[15:8]);
        if (corrupt) begin
            pos       = $urandom_range(0, body.size() - 1);
            body[pos] = body[pos] ^ (8'h01 << $urandom_range(0, 7));
        end
        if (lead_soh) begin
            put_raw(REQ_BYTE, SOH_CODE);
        end
        foreach (body[i]) begin
            put_data(body[i]);
        end
        put_raw(REQ_BYTE, EOT_CODE);
    endfunction

    // Offers one item and returns after the edge that accepted it. The sender works in
    // bursts: short ones most of the time, long gap-free stretches otherwise, with a
    // random idle gap before each burst. Valid only drops in a gap, never mid-item.
    task automatic send_item(t_in_item it);
        int gap;
        if (burst_left == 0) begin
            if ($urandom_range(0, 99) < 30) begin
                burst_left = $urandom_range(30, 120);
            end else begin
                burst_left = $urandom_range(1, 12);
            end
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk); while (!in_ready);
        sb.absorb_item(it);
        counted_items++;
    endtask

    task automatic send_queue();
        while (frame_q.size() > 0) begin
            send_item(frame_q.pop_front());
        end
    endtask

    // Stop offering and wait until every owed result has been taken. At least one edge
    // passes, so valid is never lowered and raised again in the same step.
    task automatic drain();
        in_valid <= 1'b0;
        burst_left = 0;
        do @(posedge clk); while (sb.owed_outputs.size() != 0);
    endtask

    initial begin
        byte_q_t pl;
        int      iter;
        int      pick;
        int      len;

        sb = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part. A clear with no frame held must do nothing, and an EOT with fewer
        // than two stored bytes reports a bad frame of length zero.
        put_raw(REQ_CLEAR, 8'hFF);
        put_raw(REQ_BYTE, EOT_CODE);
        // Shortest good frame: one zero byte whose CRC is zero.
        pl = {8'h00};
        put_frame(pl, 1'b1, 1'b0);
        // Bytes that arrive while a good frame is held are dropped.
        put_raw(REQ_BYTE, 8'hFF);
        put_raw(REQ_CLEAR, 8'h00);
        // Escaped framing codes are plain payload.
        pl = {SOH_CODE, DLE_CODE, EOT_CODE, 8'hFF};
        put_frame(pl, 1'b1, 1'b0);
        put_raw(REQ_CLEAR, 8'h80);
        // Trailer with no payload: the CRC matches but the frame is too short.
        pl = {};
        put_frame(pl, 1'b1, 1'b0);
        send_queue();
        drain();

        // Random part, mostly well-formed frames with random content. The buffer-wrap
        // sequence alone accounts for most of the item total.
        iter = 0;
        while (counted_items < ITEM_TARGET) begin
            iter++;
            if (iter == 5) begin
                // The receiver freezes while the sender keeps offering frames.
                hold_left = LONG_HOLD;
            end
            if (iter == 10) begin
                // Longest frame that fits, then a clear, one more byte so the count reaches
                // the buffer size, and an EOT that must see the wrapped, empty count.
                put_frame(rand_payload(BUF_BYTES - 3), 1'b1, 1'b0);
                put_raw(REQ_CLEAR, 8'h5A);
                put_raw(REQ_BYTE, 8'h33);
                put_raw(REQ_BYTE, EOT_CODE);
                send_queue();
            end
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
                case ($urandom_range(0, 9))
                    0: len = 0;
                    1: len = $urandom_range(13, 48);
                    default: len = $urandom_range(1, 12);
                endcase
                // A few frames skip the SOH and so extend whatever count is left over.
                put_frame(rand_payload(len), pick >= 5, $urandom_range(0, 99) < 15);
            end else if (pick < 75) begin
                // Frame abandoned partway; the next SOH restarts it.
                put_raw(REQ_BYTE, SOH_CODE);
                repeat ($urandom_range(1, 6)) put_data(pick_byte(25));
            end else if (pick < 92) begin
                repeat ($urandom_range(1, 8)) put_raw(REQ_BYTE, pick_byte(50));
            end else begin
                put_raw(REQ_CLEAR, 8'($urandom));
            end
            send_queue();
            if (sb.frame_held) begin
                if ($urandom_range(0, 3) == 0) begin
                    repeat ($urandom_range(1, 3)) put_raw(REQ_BYTE, 8'($urandom));
                end
                put_raw(REQ_CLEAR, 8'($urandom));
                send_queue();
            end
            if ($urandom_range(0, 99) < 3) begin
                drain();
            end
        end

        drain();
        repeat (SETTLE) @(posedge clk);
        if (sb.fail_count == 0 && sb.owed_outputs.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
